### hdl/ptp_pkg.sv
`timescale 1ns / 1ps

package ptp_pkg;

    // Default sizing of the table
    localparam int ENTRIES_DEF    = 64;
    localparam int PAYLOAD_W_DEF  = 32;
    localparam int PRIORITY_W_DEF = 16;

    // Width of the id carried on the cell command bus (covers up to 1024 entries)
    localparam int CMD_ID_W = 10;

    // Request codes
    localparam logic [2:0] REQ_ADD         = 3'd0;
    localparam logic [2:0] REQ_PROMOTE     = 3'd1;
    localparam logic [2:0] REQ_GET_MAX     = 3'd2;
    localparam logic [2:0] REQ_POP_MAX     = 3'd3;
    localparam logic [2:0] REQ_IS_VALID    = 3'd4;
    localparam logic [2:0] REQ_GET_PAYLOAD = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADID = 2'd3;

    // Operation broadcast to all cells
    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_ADD,
        CELL_PROMOTE,
        CELL_RETIRE
    } cell_op_t;

    // Command bus from the controller to the cell row
    typedef struct packed {
        cell_op_t              op;
        logic                  match;  // scan picks the entry named by id, not the max
        logic [CMD_ID_W-1:0]   id;
    } cell_cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LAUNCH,
        S_SCAN,
        S_RESULT
    } ptp_state_t;

endpackage

### hdl/ptp_cell.sv
`timescale 1ns / 1ps

module ptp_cell
    import ptp_pkg::*;
#(
    parameter int PAYLOAD_W  = PAYLOAD_W_DEF,
    parameter int PRIORITY_W = PRIORITY_W_DEF,
    parameter int ID_W       = 6,
    parameter int CELL_ID    = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_cmd_t             cmd,
    input  logic [PAYLOAD_W-1:0]  wr_payload,
    input  logic                  go_in,
    input  logic                  cin_valid,
    input  logic [ID_W-1:0]       cin_id,
    input  logic [PRIORITY_W-1:0] cin_prio,
    input  logic [PAYLOAD_W-1:0]  cin_payload,
    output logic                  go_out,
    output logic                  cout_valid,
    output logic [ID_W-1:0]       cout_id,
    output logic [PRIORITY_W-1:0] cout_prio,
    output logic [PAYLOAD_W-1:0]  cout_payload,
    output logic                  live
);

    logic                  live_reg, live_next;
    logic [PRIORITY_W-1:0] prio_reg, prio_next;
    logic [PAYLOAD_W-1:0]  payload_reg, payload_next;
    logic                  go_reg;
    logic                  cv_reg, cv_next;
    logic [ID_W-1:0]       cid_reg, cid_next;
    logic [PRIORITY_W-1:0] cprio_reg, cprio_next;
    logic [PAYLOAD_W-1:0]  cpay_reg, cpay_next;
    logic                  hit;
    logic                  take;

    assign hit = (cmd.id == CMD_ID_W'(CELL_ID));

    // Entry update from the broadcast command
    always_comb
    begin
        live_next    = live_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (hit)
        begin
            case (cmd.op)
                CELL_ADD:
                begin
                    live_next    = 1'b1;
                    prio_next    = '0;
                    payload_next = wr_payload;
                end
                CELL_PROMOTE:
                begin
                    if (prio_reg != {PRIORITY_W{1'b1}})
                        prio_next = prio_reg + PRIORITY_W'(1);
                end
                CELL_RETIRE:
                    live_next = 1'b0;
                default:
                    live_next = live_reg;
            endcase
        end
    end

    // Chain stage: replace the candidate with this entry when it wins;
    // >= lets the higher id win a tie since the scan runs upward
    always_comb
    begin
        if (cmd.match)
            take = live_reg && hit;
        else
            take = live_reg && (!cin_valid || (prio_reg >= cin_prio));
        if (take)
        begin
            cv_next    = 1'b1;
            cid_next   = ID_W'(CELL_ID);
            cprio_next = prio_reg;
            cpay_next  = payload_reg;
        end
        else
        begin
            cv_next    = cin_valid;
            cid_next   = cin_id;
            cprio_next = cin_prio;
            cpay_next  = cin_payload;
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            go_reg   <= 1'b0;
            cv_reg   <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            go_reg   <= go_in;
            cv_reg   <= cv_next;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
        cid_reg     <= cid_next;
        cprio_reg   <= cprio_next;
        cpay_reg    <= cpay_next;
    end

    assign go_out       = go_reg;
    assign cout_valid   = cv_reg;
    assign cout_id      = cid_reg;
    assign cout_prio    = cprio_reg;
    assign cout_payload = cpay_reg;
    assign live         = live_reg;

endmodule

### hdl/priority_table_with_promote.sv
`timescale 1ns / 1ps

// Priority table of ENTRIES slots handling one request transaction at a time.
// Add, is-valid, the spare codes and every rejected request go straight from
// execution to the result. Get-max, pop-max, and promote and get-payload on a
// live id run a scan token down the row of entry cells, one cell per cycle,
// before their result is ready; that walk along the cell chain sets their
// request rate.
// A new request is taken as soon as the previous one has its result in the
// output register, even while that result still waits for m_tready.
// Ids are handed out in order from 0 and never reused.

module priority_table_with_promote
    import ptp_pkg::*;
#(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int PAYLOAD_WIDTH  = PAYLOAD_W_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_W_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_id[5:0], payload[37:6], zero fill
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[1:0], result_id[7:2], result_payload[39:8],
                                   // result_priority[55:40], is_live[56], zero fill
);

    localparam int ID_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = ((ID_W > 6) ? ID_W : 6) + 1;

    ptp_state_t state_reg, state_next;

    logic [2:0]             req_reg;
    logic [5:0]             id_reg;
    logic [31:0]            pl_reg;
    logic [CNT_W-1:0]       next_free_reg, next_free_next;

    logic [1:0]             res_status_reg, res_status_next;
    logic [5:0]             res_id_reg, res_id_next;
    logic [31:0]            res_payload_reg, res_payload_next;
    logic [15:0]            res_prio_reg, res_prio_next;
    logic                   res_live_reg, res_live_next;

    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_data_reg, out_data_next;

    cell_cmd_t              cmd;
    logic [PAYLOAD_WIDTH-1:0] wr_payload;

    logic                   go_c   [ENTRIES+1];
    logic                   cv_c   [ENTRIES+1];
    logic [ID_W-1:0]        cid_c  [ENTRIES+1];
    logic [PRIORITY_WIDTH-1:0] cpr_c [ENTRIES+1];
    logic [PAYLOAD_WIDTH-1:0]  cpl_c [ENTRIES+1];
    logic [ENTRIES-1:0]     live_vec;

    logic [EXT_W-1:0]       id_ext;
    logic                   in_range;
    logic                   live_sel;
    logic                   full;
    logic                   scan_max;
    logic                   need_scan;
    logic                   scan_done;
    logic                   out_load;

    // Request decode
    assign id_ext    = EXT_W'(id_reg);
    assign in_range  = (id_ext < EXT_W'(ENTRIES));
    assign live_sel  = in_range && live_vec[id_ext[ID_W-1:0]];
    assign full      = (next_free_reg == CNT_W'(ENTRIES));
    assign scan_max  = (req_reg == REQ_GET_MAX) || (req_reg == REQ_POP_MAX);
    assign scan_done = go_c[ENTRIES];
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        unique case (req_reg) inside
            REQ_GET_MAX, REQ_POP_MAX:       need_scan = 1'b1;
            REQ_PROMOTE, REQ_GET_PAYLOAD:   need_scan = live_sel;
            default:                        need_scan = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_EXEC;
            S_EXEC:
                state_next = need_scan ? S_LAUNCH : S_RESULT;
            S_LAUNCH:
                state_next = S_SCAN;
            S_SCAN:
                if (scan_done)
                    state_next = S_RESULT;
            S_RESULT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // State outputs: cell commands, result assembly, output register
    always_comb
    begin
        s_tready         = (state_reg == S_IDLE);
        cmd.op           = CELL_NOP;
        cmd.match        = !scan_max;
        cmd.id           = CMD_ID_W'(id_ext);
        wr_payload       = PAYLOAD_WIDTH'(pl_reg);
        next_free_next   = next_free_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_payload_next = res_payload_reg;
        res_prio_next    = res_prio_reg;
        res_live_next    = res_live_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;

        unique case (state_reg)
            S_EXEC:
            begin
                res_status_next  = ST_OK;
                res_id_next      = '0;
                res_payload_next = '0;
                res_prio_next    = '0;
                res_live_next    = 1'b0;
                case (req_reg)
                    REQ_ADD:
                    begin
                        if (full)
                            res_status_next = ST_FULL;
                        else
                        begin
                            cmd.op         = CELL_ADD;
                            cmd.id         = CMD_ID_W'(next_free_reg);
                            next_free_next = next_free_reg + CNT_W'(1);
                            res_id_next    = 6'(next_free_reg);
                            res_live_next  = 1'b1;
                        end
                    end
                    REQ_PROMOTE:
                    begin
                        if (live_sel)
                            cmd.op = CELL_PROMOTE;
                        else
                            res_status_next = ST_BADID;
                    end
                    REQ_GET_PAYLOAD:
                    begin
                        if (!live_sel)
                            res_status_next = ST_BADID;
                    end
                    REQ_IS_VALID:
                    begin
                        res_id_next   = id_reg;
                        res_live_next = live_sel;
                    end
                    default:
                        res_status_next = ST_OK;
                endcase
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (cv_c[ENTRIES])
                    begin
                        res_status_next  = ST_OK;
                        res_id_next      = 6'(cid_c[ENTRIES]);
                        res_payload_next = 32'(cpl_c[ENTRIES]);
                        res_prio_next    = 16'(cpr_c[ENTRIES]);
                        res_live_next    = (req_reg != REQ_POP_MAX);
                        if (req_reg == REQ_POP_MAX)
                        begin
                            cmd.op = CELL_RETIRE;
                            cmd.id = CMD_ID_W'(cid_c[ENTRIES]);
                        end
                    end
                    else
                    begin
                        res_status_next  = ST_EMPTY;
                        res_id_next      = '0;
                        res_payload_next = '0;
                        res_prio_next    = '0;
                        res_live_next    = 1'b0;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, res_live_reg, res_prio_reg, res_payload_reg,
                                      res_id_reg, res_status_reg};
                end
            end
            default:
                cmd.op = CELL_NOP;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture and result registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= s_tuser;
            id_reg  <= s_tdata[5:0];
            pl_reg  <= s_tdata[37:6];
        end
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_payload_reg <= res_payload_next;
        res_prio_reg    <= res_prio_next;
        res_live_reg    <= res_live_next;
        out_data_reg    <= out_data_next;
    end

    // Head of the cell chain: token enters once per scan, no candidate yet
    assign go_c[0]  = (state_reg == S_LAUNCH);
    assign cv_c[0]  = 1'b0;
    assign cid_c[0] = '0;
    assign cpr_c[0] = '0;
    assign cpl_c[0] = '0;

    // Row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ptp_cell #(
            .PAYLOAD_W  (PAYLOAD_WIDTH),
            .PRIORITY_W (PRIORITY_WIDTH),
            .ID_W       (ID_W),
            .CELL_ID    (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .wr_payload   (wr_payload),
            .go_in        (go_c[i]),
            .cin_valid    (cv_c[i]),
            .cin_id       (cid_c[i]),
            .cin_prio     (cpr_c[i]),
            .cin_payload  (cpl_c[i]),
            .go_out       (go_c[i+1]),
            .cout_valid   (cv_c[i+1]),
            .cout_id      (cid_c[i+1]),
            .cout_prio    (cpr_c[i+1]),
            .cout_payload (cpl_c[i+1]),
            .live         (live_vec[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### tb/priority_table_with_promote_test.sv
`timescale 1ns / 1ps

module priority_table_with_promote_test;

    import ptp_pkg::*;

    localparam int          N_ENTRIES   = ENTRIES_DEF;
    localparam logic [15:0] PRIO_MAX    = 16'hFFFF;
    localparam logic [2:0]  REQ_SPARE6  = 3'd6;   // unused request codes
    localparam logic [2:0]  REQ_SPARE7  = 3'd7;
    localparam int          RAND_ITEMS  = 1330;
    localparam int          PAUSE_AT    = 600;    // sender waits for all responses here
    localparam int          HOLD_AT     = 300;    // response count where the sink stalls
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN       = N_ENTRIES + 16;
    localparam int          IDLE_LIMIT  = 2000;

    // Response layout on m_tdata, top field first
    typedef struct packed {
        logic [6:0]  fill;
        logic        is_live;
        logic [15:0] prio;
        logic [31:0] payload;
        logic [5:0]  id;
        logic [1:0]  status;
    } response_t;

    typedef struct {
        logic [2:0]  req;
        logic [5:0]  id;
        logic [31:0] payload;
        bit          fixed_exp;
        response_t   exp;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // entry_id[5:0], payload[37:6], zero fill
    logic [2:0]  s_tuser;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // status, result_id, result_payload, result_priority, is_live

    // Shadow copy of the table contents
    logic [31:0] shadow_payload [N_ENTRIES];
    logic [15:0] shadow_prio    [N_ENTRIES];
    bit          shadow_live    [N_ENTRIES];
    int          shadow_next_id = 0;

    response_t    pending_responses[$];
    request_row_t directed_rows[$];
    int           fail_count = 0;
    int           sent_count = 0;
    int           rx_count   = 0;
    int           idle_cycles = 0;

    priority_table_with_promote dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic response_t make_response(logic [1:0] st, logic [5:0] id,
                                                logic [31:0] pl, logic [15:0] pr,
                                                logic lv);
        response_t r;
        r = '0;
        r.status  = st;
        r.id      = id;
        r.payload = pl;
        r.prio    = pr;
        r.is_live = lv;
        return r;
    endfunction

    function automatic request_row_t make_row(logic [2:0] req, logic [5:0] id,
                                              logic [31:0] pl, bit fixed_exp,
                                              response_t exp);
        request_row_t row;
        row.req       = req;
        row.id        = id;
        row.payload   = pl;
        row.fixed_exp = fixed_exp;
        row.exp       = exp;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(request_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Apply one request to the shadow table and return the response it gives
    function automatic response_t predict_response(logic [2:0] req, logic [5:0] id,
                                                   logic [31:0] pl);
        response_t r;
        bit        hit;
        int        best;
        int        i;
        r    = '0;
        hit  = (int'(id) < shadow_next_id) && shadow_live[id];
        best = -1;
        case (req)
            REQ_ADD:
            begin
                if (shadow_next_id >= N_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    shadow_payload[shadow_next_id] = pl;
                    shadow_prio[shadow_next_id]    = '0;
                    shadow_live[shadow_next_id]    = 1'b1;
                    r = make_response(ST_OK, 6'(shadow_next_id), '0, '0, 1'b1);
                    shadow_next_id++;
                end
            end
            REQ_PROMOTE:
            begin
                if (!hit)
                    r.status = ST_BADID;
                else
                begin
                    // saturate at the top priority
                    if (shadow_prio[id] != PRIO_MAX)
                        shadow_prio[id] = shadow_prio[id] + 16'd1;
                    r = make_response(ST_OK, id, shadow_payload[id], shadow_prio[id], 1'b1);
                end
            end
            REQ_GET_MAX, REQ_POP_MAX:
            begin
                // ties go to the larger id
                for (i = 0; i < N_ENTRIES; i++)
                    if (shadow_live[i] && (best < 0 || shadow_prio[i] >= shadow_prio[best]))
                        best = i;
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r = make_response(ST_OK, 6'(best), shadow_payload[best],
                                      shadow_prio[best], req != REQ_POP_MAX);
                    if (req == REQ_POP_MAX)
                        shadow_live[best] = 1'b0;
                end
            end
            REQ_IS_VALID:
                r = make_response(ST_OK, id, '0, '0, hit);
            REQ_GET_PAYLOAD:
            begin
                if (!hit)
                    r.status = ST_BADID;
                else
                    r = make_response(ST_OK, id, shadow_payload[id], shadow_prio[id], 1'b1);
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Offer one request transaction and record what it should answer
    task automatic send_request(request_row_t row);
        int        gap;
        response_t predicted;
        gap = (((sent_count / 50) % 4) == 3) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, row.payload, row.id};
        s_tuser  <= row.req;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_response(row.req, row.id, row.payload);
        pending_responses.insert(pending_responses.size(),
                                 row.fixed_exp ? row.exp : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    // Stimulus: directed table, then random requests
    initial
    begin
        int          k;
        int          n;
        int          pop_pct;
        logic [2:0]  req;
        logic [5:0]  id;
        logic [31:0] pl;
        response_t   none;
        none     = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_ADD;

        // empty table
        add_row(make_row(REQ_GET_MAX, 6'd0, 32'd0, 1'b1,
                         make_response(ST_EMPTY, '0, '0, '0, 1'b0)));
        add_row(make_row(REQ_POP_MAX, 6'd63, 32'hFFFFFFFF, 1'b1,
                         make_response(ST_EMPTY, '0, '0, '0, 1'b0)));
        add_row(make_row(REQ_PROMOTE, 6'd0, 32'd0, 1'b1,
                         make_response(ST_BADID, '0, '0, '0, 1'b0)));
        add_row(make_row(REQ_GET_PAYLOAD, 6'd63, 32'd0, 1'b1,
                         make_response(ST_BADID, '0, '0, '0, 1'b0)));
        add_row(make_row(REQ_IS_VALID, 6'd63, 32'd0, 1'b1,
                         make_response(ST_OK, 6'd63, '0, '0, 1'b0)));
        // adds with extreme payloads
        add_row(make_row(REQ_ADD, 6'd63, 32'hFFFFFFFF, 1'b1,
                         make_response(ST_OK, 6'd0, '0, '0, 1'b1)));
        add_row(make_row(REQ_ADD, 6'd0, 32'd0, 1'b1,
                         make_response(ST_OK, 6'd1, '0, '0, 1'b1)));
        add_row(make_row(REQ_ADD, 6'd21, 32'hA5A55A5A, 1'b1,
                         make_response(ST_OK, 6'd2, '0, '0, 1'b1)));
        // all at priority zero: largest id wins
        add_row(make_row(REQ_GET_MAX, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_PROMOTE, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_PROMOTE, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_PROMOTE, 6'd1, 32'd0, 1'b0, none));
        add_row(make_row(REQ_GET_MAX, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_GET_PAYLOAD, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_IS_VALID, 6'd1, 32'd0, 1'b0, none));
        // pop the max, then the retired id is rejected
        add_row(make_row(REQ_POP_MAX, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_PROMOTE, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_GET_PAYLOAD, 6'd0, 32'd0, 1'b0, none));
        add_row(make_row(REQ_IS_VALID, 6'd0, 32'd0, 1'b0, none));
        // id past the last one handed out
        add_row(make_row(REQ_PROMOTE, 6'd5, 32'd0, 1'b1,
                         make_response(ST_BADID, '0, '0, '0, 1'b0)));
        // spare codes give an all-zero response
        add_row(make_row(REQ_SPARE6, 6'd63, 32'hFFFFFFFF, 1'b1, none));
        add_row(make_row(REQ_SPARE7, 6'd42, 32'h12345678, 1'b1, none));
        add_row(make_row(REQ_GET_MAX, 6'd0, 32'd0, 1'b0, none));

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            // once, let the whole pipeline drain before going on
            if (k == PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                while (pending_responses.size() != 0)
                    @(negedge clk);
            end
            // drain the table toward the end of the run
            pop_pct = (k >= RAND_ITEMS - 300) ? 25 : 4;
            n  = $urandom_range(0, 99);
            pl = $urandom();
            if ($urandom_range(0, 15) == 0)
                pl = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'd0;
            if ($urandom_range(0, 99) < 85 && shadow_next_id > 0)
                id = 6'($urandom_range(0, shadow_next_id - 1));
            else
                id = 6'($urandom_range(0, 63));
            if (n < 8)
                req = REQ_ADD;
            else if (n < 8 + pop_pct)
                req = REQ_POP_MAX;
            else if (n < 18 + pop_pct)
                req = REQ_GET_MAX;
            else if (n < 28 + pop_pct)
                req = REQ_IS_VALID;
            else if (n < 43 + pop_pct)
                req = REQ_GET_PAYLOAD;
            else if (n < 46 + pop_pct)
                req = ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
            else
                req = REQ_PROMOTE;
            send_request(make_row(req, id, pl, 1'b0, none));
        end
        s_tvalid <= 1'b0;

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Response sink with random back-pressure and one long stall
    initial
    begin
        int        gap;
        response_t got;
        response_t exp;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_count == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (((rx_count / 50) % 4) == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = response_t'(m_tdata);
            if (pending_responses.size() == 0)
            begin
                $error("unexpected response transaction: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp = pending_responses.pop_front();
                if (got.status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, got.status);
                    fail_count++;
                end
                if (got.id !== exp.id)
                begin
                    $error("result_id: expected %0d, got %0d", exp.id, got.id);
                    fail_count++;
                end
                if (got.payload !== exp.payload)
                begin
                    $error("result_payload: expected %h, got %h", exp.payload, got.payload);
                    fail_count++;
                end
                if (got.prio !== exp.prio)
                begin
                    $error("result_priority: expected %0d, got %0d", exp.prio, got.prio);
                    fail_count++;
                end
                if (got.is_live !== exp.is_live)
                begin
                    $error("is_live: expected %0d, got %0d", exp.is_live, got.is_live);
                    fail_count++;
                end
            end
            rx_count++;
            @(negedge clk);
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

### priority_table_with_promote.f
hdl/ptp_pkg.sv
hdl/ptp_cell.sv
hdl/priority_table_with_promote.sv
tb/priority_table_with_promote_test.sv
